// ----- src/crcdf_pkg.sv -----
// Shared types, constants and helper functions for the CRC-32 checked record deframer.
// Used by crcdf_core, crcdf_outq and subreport_crc32_deframer_top; depends on nothing.

package crcdf_pkg;

    localparam int unsigned OUTQ_DEPTH_DEF = 4;

    localparam logic [7:0]  MAX_TAPS    = 8'd64;
    localparam logic [10:0] HDR_BYTES   = 11'd36;
    localparam logic [10:0] POS_LAST_HDR = 11'd35;
    localparam logic [10:0] POS_CHECK   = 11'd39;
    localparam logic [10:0] POS_MAX     = 11'd2047;
    localparam logic [31:0] CRC_POLY    = 32'hedb88320;
    localparam logic [31:0] CRC_INIT    = 32'hffffffff;
    localparam logic [8:0]  CAP_RESET   = 9'd128;

    localparam logic [4:0] ID_SAMPLE  = 5'd16;
    localparam logic [4:0] ID_VERDICT = 5'd17;

    localparam logic [5:0] FIELD_STOP [16] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd9, 6'd14, 6'd16, 6'd18,
        6'd21, 6'd24, 6'd27, 6'd30, 6'd32, 6'd33, 6'd35, 6'd36
    };

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_TAPS = 3'd1,
        ST_CAPACITY = 3'd2,
        ST_CRC      = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

    typedef struct packed {
        logic [4:0]  field_id;
        logic [39:0] value;
        logic [6:0]  sample_index;
        logic [2:0]  status;
        logic        done_res;
    } res_t;

    typedef struct packed {
        logic [1:0] nres;
        res_t       r0;
        res_t       r1;
    } push_t;

    typedef struct packed {
        logic [4:0] id;
        logic [2:0] boff;
        logic       ends;
    } hdr_info_t;

    function automatic res_t mk_res(input logic [4:0] id, input logic [39:0] val,
                                    input logic [6:0] idx, input status_t st,
                                    input logic done);
        res_t r;
        r.field_id     = id;
        r.value        = val;
        r.sample_index = idx;
        r.status       = st;
        r.done_res     = done;
        return r;
    endfunction

    function automatic hdr_info_t hdr_info(input logic [5:0] pos);
        hdr_info_t  r;
        logic [5:0] start;
        r     = '0;
        start = '0;
        for (int i = 0; i < 16; i++) begin
            if (pos >= start && pos < FIELD_STOP[i]) begin
                r.id   = 5'(i);
                r.boff = 3'(pos - start);
                r.ends = (pos + 6'd1) == FIELD_STOP[i];
            end
            start = FIELD_STOP[i];
        end
        return r;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'b0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'b0);
        end
        return c;
    endfunction

endpackage

// ----- src/subreport_crc32_deframer_top.sv -----
// Channel      | Dir | Ports                         | Payload
// -------------+-----+-------------------------------+----------------------------------------
// byte in      | in  | s_tvalid s_tready s_tdata     | data_byte; s_tlast = last
//              |     | s_tlast                       |
// result out   | out | m_tvalid m_tready m_tdata     | value, sample_index, status; tuser =
//              |     | m_tuser m_tlast               | field_id; tlast = done_res
// config       | in  | cfg_wr_en cfg_wr_data         | sample_capacity
//
// One byte is accepted per cycle while the result queue has room; each byte is registered,
// then parsed, and its zero, one or two result words go through the result queue to m_.
// Two words from one byte leave the single output port one by one, so the queue sets the pace.
// Reset is synchronous on aresetn low and restores capacity 128 and a cleared record.
// A stall on m_tready fills the result queue and then holds s_tready low.
// Top level of the deframer; depends on crcdf_pkg, crcdf_core and crcdf_outq.

module subreport_crc32_deframer_top
    import crcdf_pkg::*;
#(
    parameter int unsigned OUTQ_DEPTH = OUTQ_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // [39:0] value, [46:40] sample_index, [49:47] status
    output logic [4:0]  m_tuser,     // [4:0] field_id
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    localparam int unsigned SPACE_W = $clog2(OUTQ_DEPTH + 2);

    logic [SPACE_W-1:0] space;
    logic               push_en;
    push_t              push;
    res_t               head;

    crcdf_core #(
        .SPACE_W (SPACE_W)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .space       (space),
        .push_en     (push_en),
        .push        (push)
    );

    crcdf_outq #(
        .DEPTH   (OUTQ_DEPTH),
        .SPACE_W (SPACE_W)
    ) u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_en (push_en),
        .push    (push),
        .space   (space),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (head)
    );

    assign m_tdata = {6'b0, head.status, head.sample_index, head.value};
    assign m_tuser = head.field_id;
    assign m_tlast = head.done_res;

endmodule

// ----- src/crcdf_core.sv -----
// Per-byte record parser: input word register, record state, CRC update and verdict logic.
// Depends on crcdf_pkg; produces up to two result words per byte for crcdf_outq.

module crcdf_core
    import crcdf_pkg::*;
#(
    parameter int unsigned SPACE_W = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tlast,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data,
    input  logic [SPACE_W-1:0] space,
    output logic               push_en,
    output push_t              push
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [8:0]  cap_reg;

    logic [10:0] pos_reg, pos_next;
    logic [31:0] crc_reg, crc_next;
    logic [39:0] acc_reg, acc_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [7:0]  taps_reg, taps_next;
    logic        vg_reg, vg_next;

    res_t        r_arr [2];
    logic [1:0]  n;
    logic        proc_en;

    always_comb begin
        logic        taps_ok;
        logic [10:0] crc_off;
        logic [10:0] off;
        logic [10:0] k;
        logic [39:0] acc_v;
        logic [31:0] rc;
        logic        vg_v;
        hdr_info_t   hi;

        pos_next  = pos_reg;
        crc_next  = crc_reg;
        acc_next  = acc_reg;
        rcrc_next = rcrc_reg;
        taps_next = taps_reg;
        vg_v      = vg_reg;
        r_arr[0]  = '0;
        r_arr[1]  = '0;
        n         = 2'd0;
        taps_ok   = taps_reg != 8'd0 && taps_reg <= MAX_TAPS;
        crc_off   = HDR_BYTES + {1'b0, taps_reg, 2'b00};
        off       = pos_reg - HDR_BYTES;
        k         = pos_reg - crc_off;
        hi        = hdr_info(pos_reg[5:0]);
        acc_v     = '0;
        rc        = rcrc_reg;

        if (!vg_reg) begin
            if (pos_reg < HDR_BYTES) begin
                crc_next = crc_byte(crc_reg, in_byte_reg);
                acc_v = acc_reg | ({32'b0, in_byte_reg} << {hi.boff, 3'b000});
                if (hi.ends) begin
                    r_arr[n[0]] = mk_res(hi.id, acc_v, 7'd0, ST_OK, 1'b0);
                    n = n + 2'd1;
                    acc_v = '0;
                end
                acc_next = acc_v;
                if (pos_reg == POS_LAST_HDR) begin
                    taps_next = in_byte_reg;
                end
            end else if (!taps_ok) begin
                if (pos_reg == POS_CHECK) begin
                    r_arr[n[0]] = mk_res(ID_VERDICT, 40'd0, 7'd0, ST_BAD_TAPS, 1'b1);
                    n = n + 2'd1;
                    vg_v = 1'b1;
                end
            end else if (pos_reg < crc_off) begin
                crc_next = crc_byte(crc_reg, in_byte_reg);
                if (!off[0]) begin
                    acc_next = {32'b0, in_byte_reg};
                end else begin
                    r_arr[n[0]] = mk_res(ID_SAMPLE, {24'b0, in_byte_reg, acc_reg[7:0]},
                                         off[7:1], ST_OK, 1'b0);
                    n = n + 2'd1;
                    acc_next = '0;
                end
                if (pos_reg == POS_CHECK && {1'b0, cap_reg} < {1'b0, taps_reg, 1'b0}) begin
                    r_arr[n[0]] = mk_res(ID_VERDICT, 40'd0, 7'd0, ST_CAPACITY, 1'b1);
                    n = n + 2'd1;
                    vg_v = 1'b1;
                end
            end else begin
                if (k < 11'd4) begin
                    rc = rcrc_reg | ({24'b0, in_byte_reg} << {k[1:0], 3'b000});
                end
                rcrc_next = rc;
                if (k == 11'd3) begin
                    r_arr[n[0]] = mk_res(ID_VERDICT, 40'd0, 7'd0,
                                         (rc == ~crc_reg) ? ST_OK : ST_CRC, 1'b1);
                    n = n + 2'd1;
                    vg_v = 1'b1;
                end
            end
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 11'd1;
            end
            if (in_last_reg && !vg_v) begin
                r_arr[n[0]] = mk_res(ID_VERDICT, 40'd0, 7'd0, ST_TRUNC, 1'b1);
                n = n + 2'd1;
                vg_v = 1'b1;
            end
        end
        vg_next = vg_v;

        if (in_last_reg) begin
            pos_next  = '0;
            crc_next  = CRC_INIT;
            acc_next  = '0;
            rcrc_next = '0;
            taps_next = '0;
            vg_next   = 1'b0;
        end
    end

    assign proc_en   = in_vld_reg && ({{(SPACE_W-2){1'b0}}, n} <= space);
    assign s_tready  = !in_vld_reg || proc_en;
    assign push_en   = proc_en;
    assign push.nres = n;
    assign push.r0   = r_arr[0];
    assign push.r1   = r_arr[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            cap_reg    <= CAP_RESET;
            pos_reg    <= '0;
            crc_reg    <= CRC_INIT;
            acc_reg    <= '0;
            rcrc_reg   <= '0;
            taps_reg   <= '0;
            vg_reg     <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (proc_en) begin
                pos_reg  <= pos_next;
                crc_reg  <= crc_next;
                acc_reg  <= acc_next;
                rcrc_reg <= rcrc_next;
                taps_reg <= taps_next;
                vg_reg   <= vg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

`ifndef SYNTH
    a_quiet_after_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && vg_reg) |-> (n == 2'd0))
        else $error("result produced after the verdict");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && in_last_reg) |=> (pos_reg == 11'd0 && !vg_reg && crc_reg == CRC_INIT))
        else $error("record state not cleared after last byte");

    a_pair_ends_in_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && n == 2'd2) |-> (push.r1.done_res && !push.r0.done_res))
        else $error("two results without a single trailing verdict");
`endif

endmodule

// ----- src/crcdf_outq.sv -----
// Result queue: takes up to two result words per cycle and hands them out one per cycle
// while m_ready is high. Depends on crcdf_pkg for the result and push types.

module crcdf_outq
    import crcdf_pkg::*;
#(
    parameter int unsigned DEPTH   = OUTQ_DEPTH_DEF,
    parameter int unsigned SPACE_W = $clog2(DEPTH + 2)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_en,
    input  push_t              push,
    output logic [SPACE_W-1:0] space,
    output logic               m_valid,
    input  logic               m_ready,
    output res_t               m_res
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    typedef logic [PW-1:0] ptr_t;

    res_t               mem [DEPTH];
    ptr_t               wr_ptr_reg, wr_ptr_next;
    ptr_t               rd_ptr_reg, rd_ptr_next;
    ptr_t               wr_ptr_p1;
    logic [SPACE_W-1:0] count_reg, count_next;
    logic [SPACE_W-1:0] pushn;
    logic               pop;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_LAST) ? '0 : p + ptr_t'(1);
    endfunction

    assign pop       = m_valid && m_ready;
    assign pushn     = push_en ? {{(SPACE_W-2){1'b0}}, push.nres} : '0;
    assign space     = SPACE_W'(DEPTH) - count_reg + {{(SPACE_W-1){1'b0}}, pop};
    assign m_valid   = count_reg != '0;
    assign m_res     = mem[rd_ptr_reg];
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);

    always_comb begin
        count_next  = count_reg + pushn - {{(SPACE_W-1){1'b0}}, pop};
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (pushn == SPACE_W'(1)) begin
            wr_ptr_next = wr_ptr_p1;
        end else if (pushn == SPACE_W'(2)) begin
            wr_ptr_next = ptr_inc(wr_ptr_p1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pushn != '0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (pushn == SPACE_W'(2)) begin
            mem[wr_ptr_p1] <= push.r1;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SPACE_W'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> (pushn <= space))
        else $error("result queue written beyond its free slots");

    a_pop_moves_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (rd_ptr_reg != $past(rd_ptr_reg)))
        else $error("read pointer did not advance on a taken word");
`endif

endmodule

// ----- dv/subreport_crc32_deframer_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for subreport_crc32_deframer_top: streams measurement records
// byte by byte, predicts every header field, sample and verdict word, and checks them in order.
// Depends on crcdf_pkg and the deframer RTL.

module subreport_crc32_deframer_top_test;
    import crcdf_pkg::*;

    localparam int HDR_END [16] = '{1, 2, 3, 4, 9, 14, 16, 18, 21, 24, 27, 30, 32, 33, 35, 36};

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [55:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [8:0]  cfg_wr_data = '0;

    logic [8:0]  cap_model    = 9'd128;
    logic [10:0] rec_pos      = '0;
    logic [31:0] rec_crc      = 32'hffff_ffff;
    logic [39:0] rec_acc      = '0;
    logic [31:0] rec_rx_crc   = '0;
    logic [7:0]  rec_taps     = '0;
    logic        verdict_sent = 1'b0;

    res_t        pending_words [$];
    logic [7:0]  record_bytes [$];
    int          error_count = 0;
    int          sent_bytes  = 0;
    bit          quiet_mode  = 1'b0;
    int          ready_left  = 0;

    subreport_crc32_deframer_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ 32'hedb8_8320) : (r >> 1);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_word(input logic [4:0] id, input logic [39:0] val,
                                      input logic [6:0] idx, input status_t st,
                                      input logic done);
        res_t w;
        w.field_id     = id;
        w.value        = val;
        w.sample_index = idx;
        w.status       = st;
        w.done_res     = done;
        pending_words.push_back(w);
    endfunction

    function automatic void clear_record();
        rec_pos      = '0;
        rec_crc      = 32'hffff_ffff;
        rec_acc      = '0;
        rec_rx_crc   = '0;
        rec_taps     = '0;
        verdict_sent = 1'b0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic is_last);
        int p;
        int crc_end;
        int f;
        int start;
        int off;
        int k;
        bit taps_good;
        if (!verdict_sent) begin
            p         = int'(rec_pos);
            taps_good = rec_taps != 8'd0 && rec_taps <= MAX_TAPS;
            crc_end   = int'(HDR_BYTES) + 4 * int'(rec_taps);
            if (p < int'(HDR_BYTES)) begin
                rec_crc = crc32_update(rec_crc, b);
                f       = 0;
                start   = 0;
                while (f < 15 && HDR_END[f] <= p) begin
                    start = HDR_END[f];
                    f++;
                end
                rec_acc = rec_acc | (40'(b) << (8 * (p - start)));
                if (p + 1 == HDR_END[f]) begin
                    push_word(5'(f), rec_acc, '0, ST_OK, 1'b0);
                    rec_acc = '0;
                end
                if (p == int'(POS_LAST_HDR)) rec_taps = b;
            end else if (!taps_good) begin
                if (p == int'(POS_CHECK)) begin
                    push_word(ID_VERDICT, '0, '0, ST_BAD_TAPS, 1'b1);
                    verdict_sent = 1'b1;
                end
            end else if (p < crc_end) begin
                off     = p - int'(HDR_BYTES);
                rec_crc = crc32_update(rec_crc, b);
                if (off % 2 == 0) begin
                    rec_acc = 40'(b);
                end else begin
                    push_word(ID_SAMPLE, {24'd0, b, rec_acc[7:0]}, 7'(off / 2), ST_OK, 1'b0);
                    rec_acc = '0;
                end
                if (p == int'(POS_CHECK) && int'(cap_model) < 2 * int'(rec_taps)) begin
                    push_word(ID_VERDICT, '0, '0, ST_CAPACITY, 1'b1);
                    verdict_sent = 1'b1;
                end
            end else begin
                k = p - crc_end;
                if (k < 4) rec_rx_crc = rec_rx_crc | (32'(b) << (8 * k));
                if (k == 3) begin
                    push_word(ID_VERDICT, '0, '0,
                              (rec_rx_crc == ~rec_crc) ? ST_OK : ST_CRC, 1'b1);
                    verdict_sent = 1'b1;
                end
            end
            if (rec_pos != 11'd2047) rec_pos = rec_pos + 11'd1;
            if (is_last && !verdict_sent) begin
                push_word(ID_VERDICT, '0, '0, ST_TRUNC, 1'b1);
                verdict_sent = 1'b1;
            end
        end
        if (is_last) clear_record();
    endfunction

    function automatic logic [7:0] fill_byte(input int fill, input int i);
        case (fill)
            1: return 8'hff;
            2: return 8'h00;
            3: case (i % 4)
                   0: return 8'h00;
                   1: return 8'h80;
                   2: return 8'hff;
                   default: return 8'h7f;
               endcase
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void build_record(input int taps, input int fill, input int body);
        logic [31:0] c;
        int          n;
        record_bytes.delete();
        for (int i = 0; i < 35; i++) record_bytes.push_back(fill_byte(fill, i));
        record_bytes.push_back(8'(taps));
        n = (body < 0) ? 4 * taps : body;
        for (int i = 0; i < n; i++) record_bytes.push_back(fill_byte(fill, i));
        if (body < 0) begin
            c = 32'hffff_ffff;
            foreach (record_bytes[i]) c = crc32_update(c, record_bytes[i]);
            c = ~c;
            for (int i = 0; i < 4; i++) record_bytes.push_back(c[8*i +: 8]);
        end
    endfunction

    function automatic void flip_bit(input int idx, input int bpos);
        record_bytes[idx] = record_bytes[idx] ^ (8'd1 << bpos);
    endfunction

    function automatic void add_junk(input int n);
        for (int i = 0; i < n; i++) record_bytes.push_back(8'($urandom));
    endfunction

    function automatic int pick_taps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 4);
        if (r < 93) return $urandom_range(5, 24);
        return 64;
    endfunction

    function automatic logic [8:0] pick_capacity();
        case ($urandom_range(0, 5))
            0: return 9'd0;
            1: return 9'd510;
            2: return 9'd128;
            3: return 9'($urandom_range(1, 8));
            default: return 9'($urandom_range(0, 510));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_bytes++;
        deframe_byte(b, is_last);
    endtask

    task automatic send_record(input int cut);
        int n;
        n = (cut > 0 && cut < record_bytes.size()) ? cut : record_bytes.size();
        for (int i = 0; i < n; i++) send_byte(record_bytes[i], i == n - 1);
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 9) == 0));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        for (int i = 0; i < 400000 && pending_words.size() != 0; i++) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [8:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cap_model = v;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_good_records();
        build_record(1, 1, -1);
        send_record(0);
        build_record(1, 2, -1);
        send_record(0);
        build_record(2, 3, -1);
        send_record(0);
        build_record(64, 0, -1);
        send_record(0);
        wait_idle();
    endtask

    task automatic test_bad_taps();
        build_record(0, 0, 4);
        send_record(0);
        build_record(65, 0, 6);
        send_record(0);
        build_record(255, 1, 2);
        send_record(0);
        wait_idle();
    endtask

    task automatic test_capacity();
        set_capacity(9'd0);
        build_record(1, 0, -1);
        send_record(0);
        set_capacity(9'd3);
        build_record(2, 0, -1);
        send_record(0);
        set_capacity(9'd4);
        build_record(2, 0, -1);
        send_record(0);
        set_capacity(9'd510);
        build_record(64, 0, -1);
        send_record(0);
        set_capacity(9'd1);
        build_record(1, 0, -1);
        send_record(0);
        set_capacity(CAP_RESET);
    endtask

    task automatic test_crc_mismatch();
        build_record(2, 0, -1);
        flip_bit(record_bytes.size() - 1, 7);
        send_record(0);
        build_record(2, 0, -1);
        flip_bit(37, 0);
        send_record(0);
        wait_idle();
    endtask

    task automatic test_truncation();
        build_record(3, 0, -1);
        send_record(1);
        build_record(3, 0, -1);
        send_record(36);
        build_record(3, 0, -1);
        send_record(39);
        build_record(3, 0, -1);
        send_record(record_bytes.size() - 1);
        wait_idle();
    endtask

    task automatic test_trailing_bytes();
        build_record(1, 0, -1);
        add_junk(3);
        send_record(0);
        wait_idle();
    endtask

    task automatic test_random_records();
        int kind;
        int taps;
        int nrec;
        nrec = 0;
        while (sent_bytes < 1450) begin
            if (nrec % 5 == 0) set_capacity(pick_capacity());
            nrec++;
            quiet_mode = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            taps = pick_taps();
            if (kind < 55) begin
                build_record(taps, 0, -1);
                if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 3));
                send_record(0);
            end else if (kind < 67) begin
                build_record(taps, 0, -1);
                flip_bit($urandom_range(0, record_bytes.size() - 1), $urandom_range(0, 7));
                send_record(0);
            end else if (kind < 77) begin
                build_record($urandom_range(0, 1) ? 0 : $urandom_range(65, 255), 0,
                             $urandom_range(0, 6));
                send_record(0);
            end else if (kind < 92) begin
                build_record(taps, 0, -1);
                send_record($urandom_range(1, record_bytes.size() - 1));
            end else begin
                send_noise($urandom_range(1, 48));
            end
        end
        quiet_mode = 1'b0;
        wait_idle();
    endtask

    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left--;
        end else if (quiet_mode) begin
            m_tready <= 1'b1;
        end else if (m_tready) begin
            ready_left = pick_gap();
            if (ready_left > 0) begin
                m_tready <= 1'b0;
                ready_left--;
            end else begin
                ready_left = $urandom_range(0, 15);
            end
        end else begin
            m_tready   <= 1'b1;
            ready_left = $urandom_range(0, 15);
        end
    end

    always @(posedge aclk) begin : check_word
        res_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: field_id %0d value %0h", m_tuser, m_tdata[39:0]);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                if (m_tuser !== want.field_id) begin
                    $error("field_id: expected %0d, actual %0d", want.field_id, m_tuser);
                    error_count++;
                end
                if (m_tdata[39:0] !== want.value) begin
                    $error("value: expected %0h, actual %0h", want.value, m_tdata[39:0]);
                    error_count++;
                end
                if (m_tdata[46:40] !== want.sample_index) begin
                    $error("sample_index: expected %0d, actual %0d",
                           want.sample_index, m_tdata[46:40]);
                    error_count++;
                end
                if (m_tdata[49:47] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[49:47]);
                    error_count++;
                end
                if (m_tlast !== want.done_res) begin
                    $error("done_res: expected %0d, actual %0d", want.done_res, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_good_records();
        test_bad_taps();
        test_capacity();
        test_crc_mismatch();
        test_truncation();
        test_trailing_bytes();
        test_random_records();
        if (pending_words.size() != 0) begin
            $error("%0d expected words never arrived", pending_words.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/crcdf_pkg.sv
src/crcdf_core.sv
src/crcdf_outq.sv
src/subreport_crc32_deframer_top.sv
dv/subreport_crc32_deframer_top_test.sv
